// File: design/owm_pkg.sv
// Shared types and constants for the 1-Wire bus master.
`timescale 1ns / 1ps
package owm_pkg;

  localparam int BITS_PER_BYTE = 8;
  localparam int COUNT_WIDTH   = 10;
  localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = $clog2(NUM_REGS);
  localparam int CFG_DATA_W    = 10;
  localparam int SHORT_W       = 8;

  localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

  // Register indexes on the config port
  localparam logic [REG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WRITE_START   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SLOT_REST     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_READ_LOW      = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_RECOVERY      = 3'd7;

  // Register reset values
  localparam logic [COUNT_WIDTH-1:0] RESET_LOW_INIT     = 10'd500;
  localparam logic [COUNT_WIDTH-1:0] PRESENCE_WAIT_INIT = 10'd70;
  localparam logic [COUNT_WIDTH-1:0] RESET_TAIL_INIT    = 10'd500;
  localparam logic [SHORT_W-1:0]     WRITE_START_INIT   = 8'd10;
  localparam logic [SHORT_W-1:0]     SLOT_REST_INIT     = 8'd50;
  localparam logic [SHORT_W-1:0]     READ_LOW_INIT      = 8'd1;
  localparam logic [SHORT_W-1:0]     READ_SAMPLE_INIT   = 8'd1;
  localparam logic [SHORT_W-1:0]     RECOVERY_INIT      = 8'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_RST_LOW   = 3'd1,
    PH_RST_WAIT  = 3'd2,
    PH_RST_TAIL  = 3'd3,
    PH_SLOT_LOW  = 3'd4,
    PH_READ_WAIT = 3'd5,
    PH_SLOT_REST = 3'd6,
    PH_RECOVERY  = 3'd7
  } owm_phase_t;

  typedef enum logic [1:0] {
    CMD_RESET = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_READ  = 2'd2
  } owm_cmd_t;

  typedef struct packed {
    logic       start_req;
    logic [1:0] func;
    logic [7:0] write_byte;
    logic       line_level;
  } owm_in_t;

  typedef struct packed {
    logic       drive_low;
    logic       busy_res;
    logic       done_res;
    logic       presence_level;
    logic [7:0] read_byte;
  } owm_out_t;

endpackage

// File: design/one_wire_bus_master_top.sv
// 1-Wire bus master: tick-driven reset, write-byte and read-byte sequencer.
// Each input transfer's result is registered in the output register.
// Throughput: one tick per cycle; a new input is taken each cycle the output
//   register is empty or being drained, so ticks run back to back.
// Reset (rst, synchronous): sequencer idle, output register empty, config
//   registers back to defaults, presence_level 1, read_byte 0.
`timescale 1ns / 1ps
module one_wire_bus_master_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  owm_pkg::owm_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output owm_pkg::owm_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [owm_pkg::REG_IDX_W-1:0]       cfg_index,
  input  logic [owm_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // Timing registers
  logic [owm_pkg::COUNT_WIDTH-1:0] reset_low_ticks;
  logic [owm_pkg::COUNT_WIDTH-1:0] presence_wait_ticks;
  logic [owm_pkg::COUNT_WIDTH-1:0] reset_tail_ticks;
  logic [owm_pkg::SHORT_W-1:0]     write_start_ticks;
  logic [owm_pkg::SHORT_W-1:0]     slot_rest_ticks;
  logic [owm_pkg::SHORT_W-1:0]     read_low_ticks;
  logic [owm_pkg::SHORT_W-1:0]     read_sample_ticks;
  logic [owm_pkg::SHORT_W-1:0]     recovery_ticks;

  // Sequencer state
  owm_pkg::owm_phase_t             phase, phase_next;
  owm_pkg::owm_cmd_t               active_command;
  logic [owm_pkg::COUNT_WIDTH-1:0] tick_count, tick_count_next;
  logic [owm_pkg::BIT_IDX_W-1:0]   bit_index, bit_index_next;
  logic [7:0]                      shift_data, shift_data_next;
  logic                            presence_hold, presence_hold_next;
  logic [7:0]                      read_hold, read_hold_next;

  // Effective state for this tick, after a possible command start
  logic                            start_ok;
  owm_pkg::owm_phase_t             cur_phase;
  owm_pkg::owm_cmd_t               cur_cmd;
  logic [owm_pkg::COUNT_WIDTH-1:0] cur_tick;
  logic [owm_pkg::BIT_IDX_W-1:0]   cur_bit;
  logic [7:0]                      cur_shift;
  logic [7:0]                      sampled_shift;

  logic [owm_pkg::COUNT_WIDTH-1:0] raw_len, phase_len, cnt;
  logic                            phase_end;
  logic                            in_xfer;
  owm_pkg::owm_out_t               result;

  assign in_ready = !out_valid || out_ready;
  assign in_xfer  = in_valid && in_ready;

  // Config writes; the user must write only while idle, which the block does not enforce
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks     <= owm_pkg::RESET_LOW_INIT;
      presence_wait_ticks <= owm_pkg::PRESENCE_WAIT_INIT;
      reset_tail_ticks    <= owm_pkg::RESET_TAIL_INIT;
      write_start_ticks   <= owm_pkg::WRITE_START_INIT;
      slot_rest_ticks     <= owm_pkg::SLOT_REST_INIT;
      read_low_ticks      <= owm_pkg::READ_LOW_INIT;
      read_sample_ticks   <= owm_pkg::READ_SAMPLE_INIT;
      recovery_ticks      <= owm_pkg::RECOVERY_INIT;
    end else if (cfg_we) begin
      case (cfg_index)
        owm_pkg::REG_RESET_LOW:     reset_low_ticks     <= cfg_data;
        owm_pkg::REG_PRESENCE_WAIT: presence_wait_ticks <= cfg_data;
        owm_pkg::REG_RESET_TAIL:    reset_tail_ticks    <= cfg_data;
        owm_pkg::REG_WRITE_START:   write_start_ticks   <= cfg_data[owm_pkg::SHORT_W-1:0];
        owm_pkg::REG_SLOT_REST:     slot_rest_ticks     <= cfg_data[owm_pkg::SHORT_W-1:0];
        owm_pkg::REG_READ_LOW:      read_low_ticks      <= cfg_data[owm_pkg::SHORT_W-1:0];
        owm_pkg::REG_READ_SAMPLE:   read_sample_ticks   <= cfg_data[owm_pkg::SHORT_W-1:0];
        owm_pkg::REG_RECOVERY:      recovery_ticks      <= cfg_data[owm_pkg::SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  // Command start: a legal request while idle begins on this same tick
  always_comb begin
    start_ok = (phase == owm_pkg::PH_IDLE) && in_data.start_req &&
               ((in_data.func == owm_pkg::CMD_RESET) ||
                (in_data.func == owm_pkg::CMD_WRITE) ||
                (in_data.func == owm_pkg::CMD_READ));
    cur_phase = phase;
    cur_cmd   = active_command;
    cur_tick  = tick_count;
    cur_bit   = bit_index;
    cur_shift = shift_data;
    if (start_ok) begin
      cur_cmd   = owm_pkg::owm_cmd_t'(in_data.func);
      cur_tick  = '0;
      cur_bit   = '0;
      cur_shift = (in_data.func == owm_pkg::CMD_WRITE) ? in_data.write_byte : 8'd0;
      cur_phase = (in_data.func == owm_pkg::CMD_RESET) ? owm_pkg::PH_RST_LOW
                                                       : owm_pkg::PH_SLOT_LOW;
    end
  end

  // Phase length; a zero register counts as one tick
  always_comb begin
    case (cur_phase)
      owm_pkg::PH_RST_LOW:   raw_len = reset_low_ticks;
      owm_pkg::PH_RST_WAIT:  raw_len = presence_wait_ticks;
      owm_pkg::PH_RST_TAIL:  raw_len = reset_tail_ticks;
      owm_pkg::PH_SLOT_LOW:
        raw_len = owm_pkg::COUNT_WIDTH'((cur_cmd == owm_pkg::CMD_WRITE) ? write_start_ticks
                                                                        : read_low_ticks);
      owm_pkg::PH_READ_WAIT: raw_len = owm_pkg::COUNT_WIDTH'(read_sample_ticks);
      owm_pkg::PH_SLOT_REST: raw_len = owm_pkg::COUNT_WIDTH'(slot_rest_ticks);
      owm_pkg::PH_RECOVERY:  raw_len = owm_pkg::COUNT_WIDTH'(recovery_ticks);
      default:               raw_len = owm_pkg::COUNT_WIDTH'(1);
    endcase
    phase_len = (raw_len == '0) ? owm_pkg::COUNT_WIDTH'(1) : raw_len;
    cnt       = cur_tick + owm_pkg::COUNT_WIDTH'(1);  // wraps at counter width
    phase_end = (cnt >= phase_len) || (cnt == '0);
  end

  // Read bit sample on the first tick of the slot rest
  always_comb begin
    sampled_shift = cur_shift;
    if ((cur_phase == owm_pkg::PH_SLOT_REST) && (cur_cmd == owm_pkg::CMD_READ) &&
        (cur_tick == '0)) begin
      sampled_shift[cur_bit] = cur_shift[cur_bit] | in_data.line_level;
    end
  end

  // Next-state logic
  always_comb begin
    phase_next         = cur_phase;
    tick_count_next    = cnt;
    bit_index_next     = cur_bit;
    shift_data_next    = sampled_shift;
    presence_hold_next = presence_hold;
    read_hold_next     = read_hold;

    if ((cur_phase == owm_pkg::PH_RST_TAIL) && (cur_tick == '0)) begin
      presence_hold_next = in_data.line_level;
    end

    if (cur_phase == owm_pkg::PH_IDLE) begin
      tick_count_next = tick_count;
    end else if (phase_end) begin
      tick_count_next = '0;
      case (cur_phase)
        owm_pkg::PH_RST_LOW:  phase_next = owm_pkg::PH_RST_WAIT;
        owm_pkg::PH_RST_WAIT: phase_next = owm_pkg::PH_RST_TAIL;
        owm_pkg::PH_RST_TAIL: phase_next = owm_pkg::PH_IDLE;
        owm_pkg::PH_SLOT_LOW: begin
          if ((cur_cmd == owm_pkg::CMD_WRITE) || (read_sample_ticks == '0)) begin
            phase_next = owm_pkg::PH_SLOT_REST;
          end else begin
            phase_next = owm_pkg::PH_READ_WAIT;
          end
        end
        owm_pkg::PH_READ_WAIT: phase_next = owm_pkg::PH_SLOT_REST;
        owm_pkg::PH_SLOT_REST: begin
          if (cur_bit == owm_pkg::LAST_BIT) begin
            if (cur_cmd == owm_pkg::CMD_READ) begin
              read_hold_next = sampled_shift;
            end
            phase_next = owm_pkg::PH_IDLE;
          end else begin
            bit_index_next = cur_bit + owm_pkg::BIT_IDX_W'(1);
            phase_next = (recovery_ticks == '0) ? owm_pkg::PH_SLOT_LOW
                                                : owm_pkg::PH_RECOVERY;
          end
        end
        default: phase_next = owm_pkg::PH_SLOT_LOW;
      endcase
    end
  end

  // Result for this tick
  always_comb begin
    result.drive_low      = 1'b0;
    result.busy_res       = (cur_phase != owm_pkg::PH_IDLE);
    result.done_res       = 1'b0;
    result.presence_level = presence_hold_next;
    result.read_byte      = read_hold_next;
    case (cur_phase)
      owm_pkg::PH_RST_LOW,
      owm_pkg::PH_SLOT_LOW:  result.drive_low = 1'b1;
      owm_pkg::PH_RST_TAIL:  result.done_res  = phase_end;
      owm_pkg::PH_SLOT_REST: begin
        // write slot: drive low for a zero bit, release for a one bit
        if (cur_cmd == owm_pkg::CMD_WRITE) begin
          result.drive_low = ~cur_shift[cur_bit];
        end
        result.done_res = phase_end && (cur_bit == owm_pkg::LAST_BIT);
      end
      default: ;
    endcase
  end

  // State registers advance once per input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= owm_pkg::PH_IDLE;
      active_command <= owm_pkg::CMD_RESET;
      tick_count     <= '0;
      bit_index      <= '0;
      shift_data     <= '0;
      presence_hold  <= 1'b1;
      read_hold      <= '0;
    end else if (in_xfer) begin
      phase          <= phase_next;
      active_command <= cur_cmd;
      tick_count     <= tick_count_next;
      bit_index      <= bit_index_next;
      shift_data     <= shift_data_next;
      presence_hold  <= presence_hold_next;
      read_hold      <= read_hold_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      out_data <= result;
    end
  end

endmodule

// File: tb/one_wire_bus_master_top_tb.sv
// Self-checking testbench for the 1-Wire bus master: random ticks, predicted line drive/status.
`timescale 1ns / 1ps
module one_wire_bus_master_top_tb;
  import owm_pkg::*;

  // Code outside the defined commands; the master must ignore it.
  localparam logic [1:0] CMD_UNDEF = 2'd3;
  // Cycles with no transfer on either side before the run is declared hung.
  // Worst honest quiet stretch is a sender gap plus a receiver stall.
  localparam int QUIET_LIMIT = 1000;
  // Idle ticks queued per round while running a command out to completion.
  localparam int DRAIN_BATCH = 8;

  logic clk;
  logic rst = 1'b1;

  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  owm_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  owm_out_t              out_data;
  logic                  cfg_we    = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  one_wire_bus_master_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shared state
  // ---------------------------------------------------------------------------
  owm_in_t  tick_q[$];        // ticks waiting to be driven
  owm_out_t bus_status_q[$];  // predicted line drive / status, oldest first
  int       mismatches   = 0;
  bit       calm         = 1'b0;  // 1: both sides run with no idle cycles
  logic     in_acc       = 1'b0;  // input transfer at the last rising edge
  logic     out_acc      = 1'b0;  // output transfer at the last rising edge
  int       send_wait    = 0;
  int       hold_cycles  = 0;
  int       quiet_cycles = 0;

  // Timing registers and sequencer state as the master should hold them
  logic [CFG_DATA_W-1:0]  tim_regs [NUM_REGS];
  owm_phase_t             seq_phase;
  owm_cmd_t               seq_cmd;
  logic [COUNT_WIDTH-1:0] seq_ticks;
  logic [BIT_IDX_W-1:0]   seq_bit;
  logic [7:0]             seq_shift;
  logic                   seq_presence;
  logic [7:0]             seq_read;

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  // ---------------------------------------------------------------------------
  // Tick predictor: advances the sequencer by one tick and returns what the
  // master should show on that tick.
  // ---------------------------------------------------------------------------
  task automatic predict_bus_tick(input owm_in_t t, output owm_out_t r);
    logic [COUNT_WIDTH-1:0] nxt;
    logic [COUNT_WIDTH-1:0] len;
    r = '0;

    // A request only starts a command from idle; the undefined code is dropped.
    if (seq_phase == PH_IDLE && t.start_req &&
        (t.func == CMD_RESET || t.func == CMD_WRITE || t.func == CMD_READ)) begin
      seq_cmd   = owm_cmd_t'(t.func);
      seq_ticks = '0;
      seq_bit   = '0;
      seq_shift = (t.func == CMD_WRITE) ? t.write_byte : 8'h00;
      seq_phase = (t.func == CMD_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
    end

    if (seq_phase != PH_IDLE) begin
      r.busy_res = 1'b1;
      case (seq_phase)
        PH_RST_LOW, PH_SLOT_LOW: begin
          r.drive_low = 1'b1;
        end
        PH_RST_TAIL: begin
          // presence answer is taken on the first tail tick
          if (seq_ticks == '0) seq_presence = t.line_level;
        end
        PH_SLOT_REST: begin
          if (seq_cmd == CMD_WRITE) begin
            r.drive_low = ~seq_shift[seq_bit];
          end else if (seq_ticks == '0) begin
            seq_shift[seq_bit] = seq_shift[seq_bit] | t.line_level;
          end
        end
        default: ;
      endcase

      // Length of the current phase; a programmed zero counts as one tick
      case (seq_phase)
        PH_RST_LOW:   len = tim_regs[REG_RESET_LOW];
        PH_RST_WAIT:  len = tim_regs[REG_PRESENCE_WAIT];
        PH_RST_TAIL:  len = tim_regs[REG_RESET_TAIL];
        PH_SLOT_LOW:  len = (seq_cmd == CMD_WRITE) ? tim_regs[REG_WRITE_START]
                                                   : tim_regs[REG_READ_LOW];
        PH_READ_WAIT: len = tim_regs[REG_READ_SAMPLE];
        PH_SLOT_REST: len = tim_regs[REG_SLOT_REST];
        PH_RECOVERY:  len = tim_regs[REG_RECOVERY];
        default:      len = COUNT_WIDTH'(1);
      endcase
      if (len == '0) len = COUNT_WIDTH'(1);

      nxt = seq_ticks + 1'b1;
      if (nxt >= len || nxt == '0) begin
        seq_ticks = '0;
        case (seq_phase)
          PH_RST_LOW:  seq_phase = PH_RST_WAIT;
          PH_RST_WAIT: seq_phase = PH_RST_TAIL;
          PH_RST_TAIL: begin
            seq_phase  = PH_IDLE;
            r.done_res = 1'b1;
          end
          PH_SLOT_LOW: begin
            // zero sample wait skips straight to the slot rest
            if (seq_cmd == CMD_WRITE || tim_regs[REG_READ_SAMPLE] == '0)
              seq_phase = PH_SLOT_REST;
            else
              seq_phase = PH_READ_WAIT;
          end
          PH_READ_WAIT: seq_phase = PH_SLOT_REST;
          PH_SLOT_REST: begin
            if (seq_bit == LAST_BIT) begin
              if (seq_cmd == CMD_READ) seq_read = seq_shift;
              seq_phase  = PH_IDLE;
              r.done_res = 1'b1;
            end else begin
              seq_bit   = seq_bit + 1'b1;
              // zero recovery skips the gap between slots
              seq_phase = (tim_regs[REG_RECOVERY] == '0) ? PH_SLOT_LOW : PH_RECOVERY;
            end
          end
          default: seq_phase = PH_SLOT_LOW;
        endcase
      end else begin
        seq_ticks = nxt;
      end
    end

    r.presence_level = seq_presence;
    r.read_byte      = seq_read;
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      mismatches++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: presents queued ticks at the falling edge, idles for a drawn gap between transfers
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      send_wait <= 0;
    end else if (!in_valid || in_acc) begin
      if (send_wait != 0) begin
        in_valid  <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (tick_q.size() != 0) begin
        in_valid  <= 1'b1;
        in_data   <= tick_q.pop_front();
        send_wait <= draw_wait();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: after each transfer, hold ready low for a drawn stall
  always @(negedge clk) begin : result_sink
    int n;
    if (rst) begin
      out_ready   <= 1'b0;
      hold_cycles <= 0;
    end else if (out_acc) begin
      n = draw_wait();
      hold_cycles <= n;
      out_ready   <= (n == 0);
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready   <= (hold_cycles == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks result transfers, predicts on input transfers, watchdog.
  // The result is checked before the new tick is predicted so the queue order
  // never depends on scheduling.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : bus_monitor
    owm_out_t want;
    owm_out_t next_status;
    if (rst) begin
      in_acc       <= 1'b0;
      out_acc      <= 1'b0;
      quiet_cycles = 0;
    end else begin
      in_acc  <= in_valid && in_ready;
      out_acc <= out_valid && out_ready;

      if (out_valid && out_ready) begin
        if (bus_status_q.size() == 0) begin
          $error("result transfer with no tick outstanding: %h", out_data);
          mismatches++;
        end else begin
          want = bus_status_q.pop_front();
          check_field("drive_low",      8'(want.drive_low),      8'(out_data.drive_low));
          check_field("busy_res",       8'(want.busy_res),       8'(out_data.busy_res));
          check_field("done_res",       8'(want.done_res),       8'(out_data.done_res));
          check_field("presence_level", 8'(want.presence_level),
                      8'(out_data.presence_level));
          check_field("read_byte",      want.read_byte,          out_data.read_byte);
        end
      end

      if (in_valid && in_ready) begin
        predict_bus_tick(in_data, next_status);
        bus_status_q.push_back(next_status);
      end

      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("Testbench completed WITH ERRORS");
          $finish;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic go, input logic [1:0] fn, input logic [7:0] data,
                           input logic lvl);
    owm_in_t t;
    t.start_req  = go;
    t.func       = fn;
    t.write_byte = data;
    t.line_level = lvl;
    tick_q.push_back(t);
  endtask

  // Config write; only called while the master is idle and no transfer is open
  task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    // short registers keep only their low byte
    tim_regs[idx] = (idx > REG_RESET_TAIL) ? {2'b00, val[SHORT_W-1:0]} : val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Loads every timing register from a range; short registers get junk in the
  // bits above their width so the masking is exercised too.
  task automatic set_timing(input int long_lo, input int long_hi,
                            input int short_lo, input int short_hi);
    for (int idx = 0; idx < NUM_REGS; idx++) begin
      if (idx <= REG_RESET_TAIL)
        write_reg(REG_IDX_W'(idx), CFG_DATA_W'($urandom_range(long_lo, long_hi)));
      else
        write_reg(REG_IDX_W'(idx), CFG_DATA_W'(($urandom_range(0, 3) << SHORT_W) |
                                               $urandom_range(short_lo, short_hi)));
    end
  endtask

  // Feeds idle ticks until the running command has finished and every
  // predicted status has been seen on the output.
  task automatic settle(input bit hold_line, input logic lvl);
    do begin
      do begin
        @(posedge clk);
        #1;
      end while (tick_q.size() != 0 || in_valid || bus_status_q.size() != 0);
      if (seq_phase != PH_IDLE)
        repeat (DRAIN_BATCH)
          push_tick(1'b0, 2'($urandom), 8'($urandom), hold_line ? lvl : 1'($urandom));
    end while (seq_phase != PH_IDLE);
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    tim_regs[REG_RESET_LOW]     = RESET_LOW_INIT;
    tim_regs[REG_PRESENCE_WAIT] = PRESENCE_WAIT_INIT;
    tim_regs[REG_RESET_TAIL]    = RESET_TAIL_INIT;
    tim_regs[REG_WRITE_START]   = CFG_DATA_W'(WRITE_START_INIT);
    tim_regs[REG_SLOT_REST]     = CFG_DATA_W'(SLOT_REST_INIT);
    tim_regs[REG_READ_LOW]      = CFG_DATA_W'(READ_LOW_INIT);
    tim_regs[REG_READ_SAMPLE]   = CFG_DATA_W'(READ_SAMPLE_INIT);
    tim_regs[REG_RECOVERY]      = CFG_DATA_W'(RECOVERY_INIT);
    seq_phase    = PH_IDLE;
    seq_cmd      = CMD_RESET;
    seq_ticks    = '0;
    seq_bit      = '0;
    seq_shift    = 8'h00;
    seq_presence = 1'b1;
    seq_read     = 8'h00;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // --- Directed: all lengths zero, so every phase collapses to one tick
    // (zero sample wait and zero recovery skip their phases entirely).
    set_timing(0, 0, 0, 0);

    // reset pulse, device answers / nobody answers
    push_tick(1'b1, CMD_RESET, 8'h00, 1'b0);
    settle(1'b1, 1'b0);
    push_tick(1'b1, CMD_RESET, 8'hFF, 1'b1);
    settle(1'b1, 1'b1);

    // write all ones while requests keep coming; those during the byte and on
    // its completion tick are dropped, the next one starts a write of zeros
    push_tick(1'b1, CMD_WRITE, 8'hFF, 1'b0);
    repeat (16) push_tick(1'b1, CMD_WRITE, 8'h00, 1'b0);
    settle(1'b1, 1'b0);

    // read with the line held high, then held low
    push_tick(1'b1, CMD_READ, 8'h00, 1'b1);
    settle(1'b1, 1'b1);
    push_tick(1'b1, CMD_READ, 8'hFF, 1'b0);
    settle(1'b1, 1'b0);

    // undefined command code: master stays idle
    push_tick(1'b1, CMD_UNDEF, 8'h5A, 1'b1);
    push_tick(1'b0, CMD_READ, 8'hA5, 1'b0);
    settle(1'b1, 1'b0);

    // --- Random phases, each under its own timing set
    for (int p = 0; p < 10; p++) begin
      calm = ($urandom_range(0, 2) == 0);
      if (p == 7)
        set_timing(20, 60, 3, 12);
      else
        set_timing(0, 6, 0, 4);
      // mostly well-formed commands; a few undefined codes mixed in
      repeat (70)
        push_tick($urandom_range(0, 3) == 0,
                  ($urandom_range(0, 7) == 0) ? CMD_UNDEF
                                              : 2'($urandom_range(CMD_RESET, CMD_READ)),
                  8'($urandom), 1'($urandom));
      settle(1'b0, 1'b0);
    end

    // settle() left nothing outstanding; give the output register time to go quiet
    repeat (4) @(posedge clk);
    if (mismatches == 0 && bus_status_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
